// File: hdl/sfps_pkg.sv
// ----------------------------------------------------------------------------
// sfps_pkg
// Types, constants and helpers shared by the stereo frame pair sync unit.
// ----------------------------------------------------------------------------
package sfps_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int FRAME_W     = 32;
  localparam int TIME_W      = 63;
  localparam int SKEW_W      = 64;
  localparam int CNT_W       = 32;
  localparam int CFG_W       = 30;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int IN_DATA_W   = 104;
  localparam int OUT_DATA_W  = 416;

  localparam int CMDQ_DEPTH  = 2;
  localparam int CMDQ_PTR_W  = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W  = $clog2(CMDQ_DEPTH + 1);

  localparam logic [CFG_W-1:0] SKEW_RESET = CFG_W'(10000000);

  localparam logic [1:0] MODE_PUSH_LEFT  = 2'd0;
  localparam logic [1:0] MODE_PUSH_RIGHT = 2'd1;
  localparam logic [1:0] MODE_PULL       = 2'd2;

  localparam logic [1:0] ST_NO_PAIR      = 2'd0;
  localparam logic [1:0] ST_PAIRED       = 2'd1;
  localparam logic [1:0] ST_LEFT_FAILED  = 2'd2;
  localparam logic [1:0] ST_RIGHT_FAILED = 2'd3;

  typedef enum logic [1:0] {
    CMD_PUSH_LEFT,
    CMD_PUSH_RIGHT,
    CMD_PULL
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [TIME_W-1:0]  time_ns;
    logic [FRAME_W-1:0] frame;
    logic               left_failed;
    logic               right_failed;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIFF,
    S_DECIDE,
    S_OUT
  } state_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  function automatic logic [PTR_W-1:0] slot_add(input logic [PTR_W-1:0] head,
                                                input logic [QCNT_W-1:0] count);
    logic [QCNT_W:0] s;
    s = (QCNT_W + 1)'(head) + (QCNT_W + 1)'(count);
    if (s >= (QCNT_W + 1)'(QUEUE_DEPTH)) begin
      s = s - (QCNT_W + 1)'(QUEUE_DEPTH);
    end
    return s[PTR_W-1:0];
  endfunction

endpackage

// File: hdl/stereo_frame_pair_sync_unit.sv
// ----------------------------------------------------------------------------
// stereo_frame_pair_sync_unit
// Pairs left and right camera frame records by capture time.
// ----------------------------------------------------------------------------
// Input words (s_*): tuser is the mode (push left, push right, pull); a push
// carries capture time and frame number, a pull carries the stream failure
// flags. Mode 3 words are taken and dropped. Pushes give no output word; each
// pull gives one output word (m_*) with status in tuser and pair data,
// latest skew and reject counters in tdata.
// Max skew is written through cfg_we/cfg_wdata; the user must do so only
// while the block is idle, which the block itself does not enforce.
// A pull walks the queue heads and does at most 2 * QUEUE_DEPTH - 1
// comparisons, each a head read, a subtract and a compare.
// A 2-entry command queue lets the input side keep accepting while a pull
// runs or an output word waits; once it and the input register fill,
// s_tready drops. When m_tready is low the finished word holds in the
// output register and the engine waits before it can finish the next pull.
// Reset empties both frame queues, clears the counters and the latest skew,
// and sets max skew to 10,000,000 ns.
// ----------------------------------------------------------------------------
module stereo_frame_pair_sync_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [1:0]                      s_tuser,  // mode
  // timestamp_ns, frame_number, left_failed, right_failed, zero fill
  input  logic [sfps_pkg::IN_DATA_W-1:0]  s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [1:0]                      m_tuser,  // status
  // pair_number, left_frame_number, right_frame_number, left_time_ns,
  // right_time_ns, pair_skew_ns, last_skew_ns, rejected_left_total,
  // rejected_right_total, zero fill
  output logic [sfps_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic                            cfg_we,
  input  logic [sfps_pkg::CFG_W-1:0]      cfg_wdata
);
  import sfps_pkg::*;

  cmd_t front_cmd;
  cmd_t back_cmd;
  logic front_valid;
  logic front_ready;
  logic back_valid;
  logic back_ready;

  sfps_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready),
    .cmd       (front_cmd)
  );

  sfps_cmd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_cmd    (front_cmd),
    .out_valid (back_valid),
    .out_ready (back_ready),
    .out_cmd   (back_cmd)
  );

  sfps_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (back_valid),
    .cmd_ready (back_ready),
    .cmd       (back_cmd),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tuser   (m_tuser),
    .m_tdata   (m_tdata)
  );

endmodule

// File: hdl/sfps_front.sv
// ----------------------------------------------------------------------------
// sfps_front
// Input stage: takes stream words, decodes the mode and registers a command.
// ----------------------------------------------------------------------------
module sfps_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [1:0]                     s_tuser,
  input  logic [sfps_pkg::IN_DATA_W-1:0] s_tdata,
  output logic                           cmd_valid,
  input  logic                           cmd_ready,
  output sfps_pkg::cmd_t                 cmd
);
  import sfps_pkg::*;

  cmd_t cmd_next;
  logic keep;

  assign s_tready = !cmd_valid || cmd_ready;

  always_comb begin
    cmd_next.time_ns      = s_tdata[TIME_W-1:0];
    cmd_next.frame        = s_tdata[TIME_W +: FRAME_W];
    cmd_next.left_failed  = s_tdata[TIME_W + FRAME_W];
    cmd_next.right_failed = s_tdata[TIME_W + FRAME_W + 1];
    cmd_next.kind         = CMD_PULL;
    keep                  = 1'b1;
    unique case (s_tuser)
      MODE_PUSH_LEFT:  cmd_next.kind = CMD_PUSH_LEFT;
      MODE_PUSH_RIGHT: cmd_next.kind = CMD_PUSH_RIGHT;
      MODE_PULL:       cmd_next.kind = CMD_PULL;
      default:         keep = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      cmd_valid <= keep;
    end else if (cmd_ready) begin
      cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cmd <= cmd_next;
    end
  end

endmodule

// File: hdl/sfps_cmd_fifo.sv
// ----------------------------------------------------------------------------
// sfps_cmd_fifo
// Short command queue between the input stage and the pairing engine.
// ----------------------------------------------------------------------------
module sfps_cmd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  sfps_pkg::cmd_t in_cmd,
  output logic           out_valid,
  input  logic           out_ready,
  output sfps_pkg::cmd_t out_cmd
);
  import sfps_pkg::*;

  cmd_t                  mem [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr;
  logic [CMDQ_PTR_W-1:0] rd_ptr;
  logic [CMDQ_CNT_W-1:0] count;
  logic                  do_wr;
  logic                  do_rd;

  assign in_ready  = count != CMDQ_CNT_W'(CMDQ_DEPTH);
  assign out_valid = count != '0;
  assign out_cmd   = mem[rd_ptr];
  assign do_wr     = in_valid && in_ready;
  assign do_rd     = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= in_cmd;
    end
  end

endmodule

// File: hdl/sfps_back.sv
// ----------------------------------------------------------------------------
// sfps_back
// Pairing engine: frame queues, head matching walk, counters, result register.
// ----------------------------------------------------------------------------
module sfps_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cmd_valid,
  output logic                            cmd_ready,
  input  sfps_pkg::cmd_t                  cmd,
  input  logic                            cfg_we,
  input  logic [sfps_pkg::CFG_W-1:0]      cfg_wdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [1:0]                      m_tuser,
  output logic [sfps_pkg::OUT_DATA_W-1:0] m_tdata
);
  import sfps_pkg::*;

  state_t state;
  state_t state_next;

  logic [TIME_W-1:0]  l_time_mem  [QUEUE_DEPTH];
  logic [FRAME_W-1:0] l_frame_mem [QUEUE_DEPTH];
  logic [TIME_W-1:0]  r_time_mem  [QUEUE_DEPTH];
  logic [FRAME_W-1:0] r_frame_mem [QUEUE_DEPTH];

  logic [TIME_W-1:0]  l_rd_time;
  logic [FRAME_W-1:0] l_rd_frame;
  logic [TIME_W-1:0]  r_rd_time;
  logic [FRAME_W-1:0] r_rd_frame;

  logic [CFG_W-1:0]  max_skew;
  logic [PTR_W-1:0]  l_head;
  logic [PTR_W-1:0]  r_head;
  logic [QCNT_W-1:0] l_count;
  logic [QCNT_W-1:0] r_count;
  logic [CNT_W-1:0]  pairs_made;
  logic [CNT_W-1:0]  l_rej;
  logic [CNT_W-1:0]  r_rej;
  logic [SKEW_W-1:0] recent_skew;
  logic [SKEW_W-1:0] diff;

  logic [1:0]         res_status;
  logic [CNT_W-1:0]   res_pnum;
  logic [FRAME_W-1:0] res_lf;
  logic [FRAME_W-1:0] res_rf;
  logic [TIME_W-1:0]  res_lt;
  logic [TIME_W-1:0]  res_rt;
  logic [SKEW_W-1:0]  res_skew;

  logic              take;
  logic              push_l;
  logic              push_r;
  logic              l_full;
  logic              r_full;
  logic [PTR_W-1:0]  l_slot;
  logic [PTR_W-1:0]  r_slot;
  logic              rd_en;
  logic              load_out;
  logic [SKEW_W-1:0] mag;
  logic              match;

  assign take   = (state == S_IDLE) && cmd_valid;
  assign push_l = take && (cmd.kind == CMD_PUSH_LEFT);
  assign push_r = take && (cmd.kind == CMD_PUSH_RIGHT);
  assign l_full = l_count == QCNT_W'(QUEUE_DEPTH);
  assign r_full = r_count == QCNT_W'(QUEUE_DEPTH);
  assign l_slot = l_full ? l_head : slot_add(l_head, l_count);
  assign r_slot = r_full ? r_head : slot_add(r_head, r_count);
  assign mag    = diff[SKEW_W-1] ? (~diff + 1'b1) : diff;
  assign match  = mag <= SKEW_W'(max_skew);

  always_comb begin
    state_next = state;
    cmd_ready  = 1'b0;
    rd_en      = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      S_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid && cmd.kind == CMD_PULL) begin
          state_next = (cmd.left_failed || cmd.right_failed) ? S_OUT : S_CHECK;
        end
      end
      S_CHECK: begin
        if (l_count == '0 || r_count == '0) begin
          state_next = S_OUT;
        end else begin
          rd_en      = 1'b1;
          state_next = S_DIFF;
        end
      end
      S_DIFF:   state_next = S_DECIDE;
      S_DECIDE: state_next = S_CHECK;
      S_OUT: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // queue storage, registered head read
  always_ff @(posedge clk) begin
    if (push_l) begin
      l_time_mem[l_slot]  <= cmd.time_ns;
      l_frame_mem[l_slot] <= cmd.frame;
    end
    if (push_r) begin
      r_time_mem[r_slot]  <= cmd.time_ns;
      r_frame_mem[r_slot] <= cmd.frame;
    end
    if (rd_en) begin
      l_rd_time  <= l_time_mem[l_head];
      l_rd_frame <= l_frame_mem[l_head];
      r_rd_time  <= r_time_mem[r_head];
      r_rd_frame <= r_frame_mem[r_head];
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DIFF) begin
      diff <= {1'b0, l_rd_time} - {1'b0, r_rd_time};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_skew    <= SKEW_RESET;
      l_head      <= '0;
      r_head      <= '0;
      l_count     <= '0;
      r_count     <= '0;
      pairs_made  <= '0;
      l_rej       <= '0;
      r_rej       <= '0;
      recent_skew <= '0;
    end else begin
      if (cfg_we) begin
        max_skew <= cfg_wdata;
      end
      if (push_l) begin
        if (l_full) begin
          l_head <= ptr_inc(l_head);
          l_rej  <= l_rej + 1'b1;
        end else begin
          l_count <= l_count + 1'b1;
        end
      end
      if (push_r) begin
        if (r_full) begin
          r_head <= ptr_inc(r_head);
          r_rej  <= r_rej + 1'b1;
        end else begin
          r_count <= r_count + 1'b1;
        end
      end
      if (state == S_DECIDE) begin
        priority if (match) begin
          pairs_made  <= pairs_made + 1'b1;
          recent_skew <= diff;
          l_head      <= ptr_inc(l_head);
          r_head      <= ptr_inc(r_head);
          l_count     <= l_count - 1'b1;
          r_count     <= r_count - 1'b1;
        end else if (diff[SKEW_W-1]) begin
          l_head  <= ptr_inc(l_head);
          l_count <= l_count - 1'b1;
          l_rej   <= l_rej + 1'b1;
        end else begin
          r_head  <= ptr_inc(r_head);
          r_count <= r_count - 1'b1;
          r_rej   <= r_rej + 1'b1;
        end
      end
    end
  end

  // per-pull result, cleared when the pull starts
  always_ff @(posedge clk) begin
    if (take && cmd.kind == CMD_PULL) begin
      res_pnum <= '0;
      res_lf   <= '0;
      res_rf   <= '0;
      res_lt   <= '0;
      res_rt   <= '0;
      res_skew <= '0;
      priority if (cmd.left_failed) begin
        res_status <= ST_LEFT_FAILED;
      end else if (cmd.right_failed) begin
        res_status <= ST_RIGHT_FAILED;
      end else begin
        res_status <= ST_NO_PAIR;
      end
    end else if (state == S_DECIDE && match) begin
      res_status <= ST_PAIRED;
      res_pnum   <= pairs_made + 1'b1;
      res_lf     <= l_rd_frame;
      res_rf     <= r_rd_frame;
      res_lt     <= l_rd_time;
      res_rt     <= r_rd_time;
      res_skew   <= diff;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tuser <= res_status;
      m_tdata <= {2'b00, r_rej, l_rej, recent_skew, res_skew, res_rt, res_lt,
                  res_rf, res_lf, res_pnum};
    end
  end

endmodule

// File: hdl/sfps_checker.sv
// ----------------------------------------------------------------------------
// sfps_checker
// Port-level checks for the stereo frame pair sync unit.
// ----------------------------------------------------------------------------
module sfps_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [1:0]                      m_tuser,
  input logic [sfps_pkg::OUT_DATA_W-1:0] m_tdata
);
  import sfps_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output word changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

  a_nopair_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ST_PAIRED |-> m_tdata[285:0] == '0)
    else $error("pair fields not zero without a pair");

  a_pair_skew: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_PAIRED |-> m_tdata[285:222] == m_tdata[349:286])
    else $error("pair skew differs from latest skew");

endmodule

bind stereo_frame_pair_sync_unit sfps_checker u_sfps_checker (.*);
